[rtl/fcg_pkg.sv]
// package for the frame compressor gate
// types, register indexes, stage codes and widths; no dependencies
package fcg_pkg;

    localparam int FRAME_LEN = 256;
    localparam int POS_W     = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
    localparam int BIN_W     = 32;
    localparam int STORE_W   = 2 * BIN_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int CNT_W     = 9;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_SHIFT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LIMIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LIMIT   = 2'd3;

    // stage codes as seen on the result
    localparam logic [1:0] CODE_MONITOR  = 2'd0;
    localparam logic [1:0] CODE_ATTACK   = 2'd1;
    localparam logic [1:0] CODE_COMPRESS = 2'd2;
    localparam logic [1:0] CODE_RELEASE  = 2'd3;

    typedef enum logic [3:0] {
        ST_MONITOR  = 4'b0001,
        ST_ATTACK   = 4'b0010,
        ST_COMPRESS = 4'b0100,
        ST_RELEASE  = 4'b1000
    } stage_t;

    typedef struct packed {
        logic signed [15:0]      sample;
        logic signed [BIN_W-1:0] bin_re;
        logic signed [BIN_W-1:0] bin_im;
    } req_t;

    typedef struct packed {
        logic signed [BIN_W-1:0] out_re;
        logic signed [BIN_W-1:0] out_im;
        logic                    out_valid;
        logic                    out_last;
        logic [1:0]              stage;
    } rsp_t;

    // per-request info that travels alongside the buffer read
    typedef struct packed {
        logic       scaled;
        logic       primed;
        logic       last;
        logic [1:0] stage;
    } side_t;

endpackage

[rtl/frame_compressor_gate_unit.sv]
// top level of the frame compressor gate
// depends on fcg_pkg, fcg_ram, fcg_ctrl, fcg_out
//
// frame compressor gate: requests arrive in frames of FRAME_LEN positions, each
// with a time sample and a complex bin. a frame is hot when any sample magnitude
// exceeds level_threshold; at the last position of a frame the stage machine
// (monitor, attack, compress, release) advances once. each request returns one
// response carrying the bin stored at the same position one frame earlier,
// arithmetic-shifted right by ratio_shift when that frame was marked for
// compression. one request is taken per clock cycle unless rsp_ready holds the
// result path; a response passes the frame buffer read register and then the
// result register. the frame buffer is a single ram read and written at the same
// position in the same cycle, read-first. during the first frame out_valid
// is 0 and the bins read as zero, so the buffer needs no clearing after reset.
// configuration writes take effect at once and are meant for idle periods.
module frame_compressor_gate_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [fcg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fcg_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  fcg_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output fcg_pkg::rsp_t                 rsp
);

    logic                          accept;
    logic [fcg_pkg::POS_W-1:0]     pos;
    fcg_pkg::side_t                side;
    logic [3:0]                    ratio_shift;
    logic [fcg_pkg::STORE_W-1:0]   rdata;
    logic                          can_take;

    // a request is taken whenever the read stage is free or moving on
    assign req_ready = can_take;
    assign accept    = req_valid && can_take;

    // frame position, hot detect and stage machine
    fcg_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .sample      (req.sample),
        .pos         (pos),
        .side        (side),
        .ratio_shift (ratio_shift)
    );

    // frame buffer: old bin read and new bin written at the same position
    fcg_ram #(
        .WIDTH (fcg_pkg::STORE_W),
        .DEPTH (fcg_pkg::FRAME_LEN)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (pos),
        .wdata ({req.bin_re, req.bin_im}),
        .re    (accept),
        .raddr (pos),
        .rdata (rdata)
    );

    // scaling and result register
    fcg_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (accept),
        .side_in     (side),
        .rdata       (rdata),
        .ratio_shift (ratio_shift),
        .can_take    (can_take),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

endmodule

[rtl/fcg_ram.sv]
// generic single-write, single-read ram with registered read data
// read-first on a same-address access; no dependencies
module fcg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

[rtl/fcg_ctrl.sv]
// frame control: configuration registers, frame position, hot detect, stage machine
// depends on fcg_pkg
module fcg_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [fcg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fcg_pkg::CFG_DAT_W-1:0]    cfg_data,
    input  logic                             accept,
    input  logic signed [15:0]               sample,
    output logic [fcg_pkg::POS_W-1:0]        pos,
    output fcg_pkg::side_t                   side,
    output logic [3:0]                       ratio_shift
);

    logic [15:0]                   level_threshold_reg;
    logic [3:0]                    ratio_shift_reg;
    logic [7:0]                    attack_limit_reg;
    logic [7:0]                    release_limit_reg;

    fcg_pkg::stage_t               stage_reg, stage_next;
    logic [fcg_pkg::CNT_W-1:0]     attack_count_reg, attack_count_next;
    logic [fcg_pkg::CNT_W-1:0]     release_count_reg, release_count_next;
    logic                          frame_hot_reg;
    logic [fcg_pkg::POS_W-1:0]     position_reg;
    logic                          buffered_scaled_reg;
    logic                          primed_reg;

    logic [16:0]                   sample_ext;
    logic [16:0]                   mag;
    logic                          hot;
    logic                          last;
    logic [fcg_pkg::CNT_W-1:0]     attack_inc;
    logic [fcg_pkg::CNT_W-1:0]     release_inc;
    logic [1:0]                    stage_code;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_threshold_reg <= 16'd5000;
            ratio_shift_reg     <= 4'd2;
            attack_limit_reg    <= 8'd5;
            release_limit_reg   <= 8'd50;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                fcg_pkg::REG_LEVEL_THRESHOLD: level_threshold_reg <= cfg_data;
                fcg_pkg::REG_RATIO_SHIFT:     ratio_shift_reg     <= cfg_data[3:0];
                fcg_pkg::REG_ATTACK_LIMIT:    attack_limit_reg    <= cfg_data[7:0];
                fcg_pkg::REG_RELEASE_LIMIT:   release_limit_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign sample_ext  = {sample[15], sample};
    assign mag         = sample[15] ? 17'(~sample_ext + 17'd1) : sample_ext;
    assign hot         = frame_hot_reg | (mag > {1'b0, level_threshold_reg});
    assign last        = (position_reg == fcg_pkg::POS_W'(fcg_pkg::FRAME_LEN - 1));
    assign attack_inc  = fcg_pkg::CNT_W'(attack_count_reg + 1'b1);
    assign release_inc = fcg_pkg::CNT_W'(release_count_reg + 1'b1);

    // stage machine, evaluated at the end of a frame
    always_comb
    begin
        stage_next         = stage_reg;
        attack_count_next  = attack_count_reg;
        release_count_next = release_count_reg;
        unique case (stage_reg)
            fcg_pkg::ST_ATTACK:
            begin
                if (hot)
                begin
                    attack_count_next = attack_inc;
                    if (attack_inc > {1'b0, attack_limit_reg})
                    begin
                        stage_next = fcg_pkg::ST_COMPRESS;
                    end
                end
                else
                begin
                    stage_next = fcg_pkg::ST_MONITOR;
                end
            end
            fcg_pkg::ST_COMPRESS:
            begin
                if (!hot)
                begin
                    stage_next         = fcg_pkg::ST_RELEASE;
                    release_count_next = '0;
                end
            end
            fcg_pkg::ST_RELEASE:
            begin
                if (hot)
                begin
                    stage_next = fcg_pkg::ST_COMPRESS;
                end
                else
                begin
                    release_count_next = release_inc;
                    if (release_inc > {1'b0, release_limit_reg})
                    begin
                        stage_next = fcg_pkg::ST_MONITOR;
                    end
                end
            end
            default:
            begin
                if (hot)
                begin
                    stage_next        = fcg_pkg::ST_ATTACK;
                    attack_count_next = '0;
                end
            end
        endcase
        if (!last)
        begin
            stage_next         = stage_reg;
            attack_count_next  = attack_count_reg;
            release_count_next = release_count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg           <= fcg_pkg::ST_MONITOR;
            attack_count_reg    <= '0;
            release_count_reg   <= '0;
            frame_hot_reg       <= 1'b0;
            position_reg        <= '0;
            buffered_scaled_reg <= 1'b0;
            primed_reg          <= 1'b0;
        end
        else if (accept)
        begin
            stage_reg         <= stage_next;
            attack_count_reg  <= attack_count_next;
            release_count_reg <= release_count_next;
            if (last)
            begin
                buffered_scaled_reg <= (stage_reg == fcg_pkg::ST_COMPRESS)
                                     || (stage_reg == fcg_pkg::ST_RELEASE);
                frame_hot_reg       <= 1'b0;
                primed_reg          <= 1'b1;
                position_reg        <= '0;
            end
            else
            begin
                frame_hot_reg <= hot;
                position_reg  <= fcg_pkg::POS_W'(position_reg + 1'b1);
            end
        end
    end

    always_comb
    begin
        unique case (stage_next)
            fcg_pkg::ST_ATTACK:   stage_code = fcg_pkg::CODE_ATTACK;
            fcg_pkg::ST_COMPRESS: stage_code = fcg_pkg::CODE_COMPRESS;
            fcg_pkg::ST_RELEASE:  stage_code = fcg_pkg::CODE_RELEASE;
            default:              stage_code = fcg_pkg::CODE_MONITOR;
        endcase
    end

    assign pos         = position_reg;
    assign side.scaled = buffered_scaled_reg;
    assign side.primed = primed_reg;
    assign side.last   = last;
    assign side.stage  = stage_code;
    assign ratio_shift = ratio_shift_reg;

endmodule

[rtl/fcg_out.sv]
// result path: tracks the buffer read in flight, scales the bin, holds the result register
// depends on fcg_pkg
module fcg_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          issue,
    input  fcg_pkg::side_t                side_in,
    input  logic [fcg_pkg::STORE_W-1:0]   rdata,
    input  logic [3:0]                    ratio_shift,
    output logic                          can_take,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output fcg_pkg::rsp_t                 rsp
);

    logic                    s1_valid_reg, s1_valid_next;
    fcg_pkg::side_t          s1_side_reg;
    logic                    rsp_valid_reg, rsp_valid_next;
    fcg_pkg::rsp_t           rsp_reg;
    logic                    advance;
    logic [3:0]              shamt;
    logic signed [fcg_pkg::BIN_W-1:0] rd_re, rd_im;
    logic signed [fcg_pkg::BIN_W-1:0] sh_re, sh_im;
    fcg_pkg::rsp_t           rsp_new;

    assign advance        = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign can_take       = !s1_valid_reg || !rsp_valid_reg || rsp_ready;
    assign s1_valid_next  = issue || (s1_valid_reg && !advance);
    assign rsp_valid_next = advance || (rsp_valid_reg && !rsp_ready);

    assign rd_re = rdata[fcg_pkg::STORE_W-1:fcg_pkg::BIN_W];
    assign rd_im = rdata[fcg_pkg::BIN_W-1:0];
    assign shamt = s1_side_reg.scaled ? ratio_shift : 4'd0;

    // arithmetic shift, rounds toward minus infinity
    assign sh_re = rd_re >>> shamt;
    assign sh_im = rd_im >>> shamt;

    // responses carry zero bins until the first frame is complete
    always_comb
    begin
        rsp_new.out_re    = s1_side_reg.primed ? sh_re : '0;
        rsp_new.out_im    = s1_side_reg.primed ? sh_im : '0;
        rsp_new.out_valid = s1_side_reg.primed;
        rsp_new.out_last  = s1_side_reg.last;
        rsp_new.stage     = s1_side_reg.stage;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_side_reg <= side_in;
        end
        if (advance)
        begin
            rsp_reg <= rsp_new;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
